// ===== design/cft_pkg.sv =====
// Shared constants, types and helpers for the client flow table.
// No dependencies; every other design file imports this package.
package cft_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 128;
    localparam int LIVE_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int GROUP_CELLS   = 16;
    localparam int GROUPS        = (TABLE_ENTRIES + GROUP_CELLS - 1) / GROUP_CELLS;
    localparam int PAD_CELLS     = GROUPS * GROUP_CELLS;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FLOWS_W  = 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_COUNTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    // Value of is_shutdown that marks the shutdown command
    localparam logic SHUTDOWN = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_key;

    typedef struct packed {
        t_key             key;
        logic [CNT_W-1:0] count;
    } t_entry;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic live;    // cell holds a live entry
        logic hit_en;  // capture the key compare
        logic wr_new;  // load the new flow with a count of one
        logic shift;   // take the entry of the next cell
        logic incr;    // bump the count if this cell hit
    } t_cell_ctl;

    // Saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
        sat_inc = (value == {CNT_W{1'b1}}) ? value : value + CNT_W'(1);
    endfunction

endpackage

// ===== design/cft_if.sv =====
// Valid/ready channel interfaces for the flow table input and result.
// Depends on cft_pkg for field widths.
interface cft_in_if;
    import cft_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_address;
    logic [PORT_W-1:0] source_port;
    logic              is_shutdown;

    modport source (output valid, source_address, source_port, is_shutdown, input ready);
    modport sink   (input valid, source_address, source_port, is_shutdown, output ready);
endinterface

interface cft_out_if;
    import cft_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    message_number;
    logic [FLOWS_W-1:0]  flows_in_use;

    modport source (output valid, status, message_number, flows_in_use, input ready);
    modport sink   (input valid, status, message_number, flows_in_use, output ready);
endinterface

// ===== design/cft_cell.sv =====
// One table cell: holds a flow key and its counter, compares against the
// broadcast key and takes its neighbor's entry when the gap closes. Uses cft_pkg.
module cft_cell import cft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_key      i_key,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_hit;

    // Capture the key compare for live entries only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.hit_en) begin
            r_hit <= i_ctl.live && (r_entry.key == i_key);
        end
    end

    // Select the next entry: new flow, shift from neighbor, or count
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.wr_new) begin
            n_entry.key   = i_key;
            n_entry.count = CNT_W'(1);
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end else if (i_ctl.incr && r_hit) begin
            n_entry.count = sat_inc(r_entry.count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ===== design/cft_gather.sv =====
// Registered reduction over one group of cells: any-hit flag and the
// count of the hitting cell (at most one hits). Uses cft_pkg.
module cft_gather import cft_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [GROUP_CELLS-1:0] i_hit,
    input  logic [CNT_W-1:0]       i_count [GROUP_CELLS],
    output logic                   o_any,
    output logic [CNT_W-1:0]       o_count
);

    logic             r_any;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Merge the masked counts of the group
    always_comb begin
        n_count = '0;
        for (int j = 0; j < GROUP_CELLS; j++) begin
            n_count = n_count | (i_hit[j] ? i_count[j] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_any   <= |i_hit;
            r_count <= n_count;
        end
    end

    assign o_any   = r_any;
    assign o_count = r_count;

endmodule

// ===== design/client_flow_table_with_counters.sv =====
// Client flow table with per-flow message counters: top level.
// Depends on cft_pkg, cft_if, cft_cell and cft_gather.
//
// Usage:
//   i_flow   (valid/ready sink) carries source_address, source_port and
//            is_shutdown for one received packet.
//   o_result (valid/ready source) carries status, message_number and
//            flows_in_use, exactly one result per accepted item.
// Sequencing:
//   The table is a row of cells, one per flow. An item runs through four
//   sequencer steps after its transfer: key compare in every cell, group
//   reduction of hit and count, global resolve, then apply. Input is ready
//   only in the idle state, so a new item is taken only after the previous
//   one has left apply. The apply step writes the result register; it waits
//   there while a previous result is still not taken, so a stalled receiver
//   holds the block after one item, and no result is lost.
// Reset:
//   Synchronous, active low. The live count goes to zero and the table reads
//   as empty; cell contents are left as they are and never read until written.
module client_flow_table_with_counters import cft_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cft_in_if.sink     i_flow,
    cft_out_if.source  o_result
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_GATHER  = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_APPLY   = 3'd4;

    localparam int EXT_W = (LIVE_W > FLOWS_W) ? LIVE_W : FLOWS_W;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    t_key                r_key;
    logic                r_shut;
    logic [LIVE_W-1:0]   r_live;
    logic [LIVE_W-1:0]   n_live;
    logic                r_found;
    logic [CNT_W-1:0]    r_cnt_old;
    logic [GROUPS-1:0]   r_before;
    logic [GROUPS-1:0]   n_before;
    logic [CNT_W-1:0]    n_cnt_old;

    logic                r_ov;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]    r_number;
    logic [FLOWS_W-1:0]  r_flows;
    logic [STATUS_W-1:0] n_status;
    logic [CNT_W-1:0]    n_number;
    logic [EXT_W-1:0]    live_ext;

    logic                in_xfer;
    logic                go;
    logic                full;
    logic                append;
    logic                do_remove;
    logic                do_append;
    logic                do_count;

    t_cell_ctl           cell_ctl   [TABLE_ENTRIES];
    t_entry              cell_entry [TABLE_ENTRIES];
    t_entry              cell_next  [TABLE_ENTRIES];
    logic [PAD_CELLS-1:0] hit_pad;
    logic [CNT_W-1:0]    cnt_pad    [PAD_CELLS];
    logic [GROUPS-1:0]   grp_any;
    logic [CNT_W-1:0]    grp_cnt    [GROUPS];

    assign in_xfer      = i_flow.valid && i_flow.ready;
    assign i_flow.ready = (r_state == ST_IDLE);

    // Apply decision
    assign go        = (r_state == ST_APPLY) && (!r_ov || o_result.ready);
    assign full      = (r_live == LIVE_W'(TABLE_ENTRIES));
    assign append    = !r_found && !full;
    assign do_remove = go && r_found && (r_shut == SHUTDOWN);
    assign do_append = go && append && (r_shut != SHUTDOWN);
    assign do_count  = go && r_found && (r_shut != SHUTDOWN);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (in_xfer) n_state = ST_MATCH;
            ST_MATCH:   n_state = ST_GATHER;
            ST_GATHER:  n_state = ST_RESOLVE;
            ST_RESOLVE: n_state = ST_APPLY;
            ST_APPLY:   if (go) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item key on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key.addr <= i_flow.source_address;
            r_key.port <= i_flow.source_port;
            r_shut     <= i_flow.is_shutdown;
        end
    end

    // Row of cells, each fed by its right neighbor
    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            localparam int G = k / GROUP_CELLS;
            logic shift_k;

            assign shift_k = r_before[G] | (|hit_pad[k:G*GROUP_CELLS]);

            assign cell_ctl[k].live   = (LIVE_W'(k) < r_live);
            assign cell_ctl[k].hit_en = (r_state == ST_MATCH);
            assign cell_ctl[k].wr_new = do_append && (LIVE_W'(k) == r_live);
            assign cell_ctl[k].shift  = do_remove && shift_k;
            assign cell_ctl[k].incr   = do_count;

            if (k + 1 < TABLE_ENTRIES) begin : g_link
                assign cell_next[k] = cell_entry[k + 1];
            end else begin : g_end
                assign cell_next[k] = '0;
            end

            cft_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (r_key),
                .i_ctl   (cell_ctl[k]),
                .i_next  (cell_next[k]),
                .o_entry (cell_entry[k]),
                .o_hit   (hit_pad[k])
            );
            assign cnt_pad[k] = cell_entry[k].count;
        end

        // Padding beyond the last cell never hits
        for (k = TABLE_ENTRIES; k < PAD_CELLS; k++) begin : g_pad
            assign hit_pad[k] = 1'b0;
            assign cnt_pad[k] = '0;
        end

        // One registered reduction per group
        for (k = 0; k < GROUPS; k++) begin : g_grp
            cft_gather u_gather (
                .i_clk   (i_clk),
                .i_en    (r_state == ST_GATHER),
                .i_hit   (hit_pad[k*GROUP_CELLS +: GROUP_CELLS]),
                .i_count (cnt_pad[k*GROUP_CELLS +: GROUP_CELLS]),
                .o_any   (grp_any[k]),
                .o_count (grp_cnt[k])
            );
        end
    endgenerate

    // Resolve across groups: found flag, old count, groups ahead of each group
    always_comb begin
        n_cnt_old = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_cnt_old   = n_cnt_old | grp_cnt[g];
            n_before[g] = |(grp_any & ((GROUPS'(1) << g) - GROUPS'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESOLVE) begin
            r_found   <= |grp_any;
            r_cnt_old <= n_cnt_old;
            r_before  <= n_before;
        end
    end

    // Next live count and result fields
    always_comb begin
        n_live = r_live;
        if (do_remove) begin
            n_live = r_live - LIVE_W'(1);
        end else if (do_append) begin
            n_live = r_live + LIVE_W'(1);
        end

        if (!r_found && full) begin
            n_status = STATUS_DROPPED;
        end else if (r_shut == SHUTDOWN) begin
            n_status = STATUS_REMOVED;
        end else begin
            n_status = STATUS_COUNTED;
        end

        if (r_found && (r_shut != SHUTDOWN)) begin
            n_number = sat_inc(r_cnt_old);
        end else if (append && (r_shut != SHUTDOWN)) begin
            n_number = CNT_W'(1);
        end else begin
            n_number = '0;
        end
    end

    assign live_ext = EXT_W'(n_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else begin
            r_live <= n_live;
        end
    end

    // Result register: hold until the receiver takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (go) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_status <= n_status;
            r_number <= n_number;
            r_flows  <= live_ext[FLOWS_W-1:0];
        end
    end

    assign o_result.valid          = r_ov;
    assign o_result.status         = r_status;
    assign o_result.message_number = r_number;
    assign o_result.flows_in_use   = r_flows;

`ifndef SYNTH
    // Live count never exceeds the table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LIVE_W'(TABLE_ENTRIES))
        else $error("live count above table size");

    // Keys are unique, so at most one cell hits
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |-> $onehot0(hit_pad))
        else $error("more than one cell matched the key");

    // Live count moves only in the apply step
    a_live_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_APPLY) |=> $stable(r_live))
        else $error("live count changed outside apply");

    // Number is zero unless the item was counted
    a_number_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_status != STATUS_COUNTED)) |-> (r_number == '0))
        else $error("nonzero message number on a non-counted result");
`endif

endmodule
